FILE: sv/mtp_pkg.sv
// shared constants, types and the tempering function for the twister generator
`timescale 1ns / 1ps
`default_nettype none

package mtp_pkg;

  localparam int WORD_W              = 32;
  localparam int STATE_WORDS_DEFAULT = 624;
  localparam int TWIST_OFFSET        = 397;

  // configuration map
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] ADDR_SEED_MODE = 3'd0;

  // seeding rules
  localparam logic [1:0] MODE_KNUTH    = 2'd0;
  localparam logic [1:0] MODE_CLASSIC  = 2'd1;
  localparam logic [1:0] MODE_IMPROVED = 2'd2;

  // commands
  localparam logic OP_NEXT = 1'b0;
  localparam logic OP_SEED = 1'b1;

  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_B0DF;
  localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9D2C_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hEFC6_0000;
  localparam logic [WORD_W-1:0] HALF_MASK    = 32'hFFFF_0000;
  localparam logic [WORD_W-1:0] KNUTH_MUL    = 32'd69069;
  // two lcg steps folded: s'' = 69069^2 * s + (69069 + 1)
  localparam logic [WORD_W-1:0] KNUTH_SQ     = 32'd475559465;
  localparam logic [WORD_W-1:0] CLASSIC_ADD  = 32'd69070;
  localparam logic [WORD_W-1:0] INIT_MUL     = 32'd1812433253;

  typedef struct packed {
    logic busy;
    logic shift;
  } seed_status_t;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] y_in);
    logic [WORD_W-1:0] y;
    y = y_in;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

`default_nettype wire

FILE: sv/mersenne_twister_prng_top.sv
// top level of the twister generator: cell chain, seeder, twist tap and ports
`timescale 1ns / 1ps
`default_nettype none

// The 624-word generator state lives in a ring of word cells that shift
// towards cell 0. On a next command the new word is formed from cells 0,
// 1 and 397, shifted into the tail, tempered and registered as the output
// word, so next commands are taken one per clock while the output side
// keeps up. Twisting is thus spread over the next commands and gives the
// same word sequence as regenerating the whole store at once. A seed
// command gives no output word and holds off the input channel while the
// seeder pushes one word per cycle into the chain. seed_mode picks the
// seeding rule and is sampled when the seed command is accepted. A next
// command before the first seed returns an undefined word.
module mersenne_twister_prng_top
  import mtp_pkg::*;
#(
  parameter int STATE_WORDS = STATE_WORDS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // command input
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_opcode,
  input  wire logic [WORD_W-1:0]     in_seed_value,
  // output words
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [WORD_W-1:0]     out_random_word,
  // configuration
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  logic [1:0]        seed_mode_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;

  logic              in_acc;
  logic              next_acc;
  logic              seed_acc;
  logic              shift_en;
  logic [WORD_W-1:0] feed;
  logic [WORD_W-1:0] twist_y;
  logic [WORD_W-1:0] twist_v;
  logic [WORD_W-1:0] seed_word;
  seed_status_t      seed_stat;

  logic [WORD_W-1:0] tap [STATE_WORDS];

  // ---------------------------------------------------------------
  // configuration port, single register at address 0
  // ---------------------------------------------------------------
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_mode_r <= MODE_IMPROVED;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr == ADDR_SEED_MODE)) begin
      seed_mode_r <= cfg_pwdata[1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr == ADDR_SEED_MODE) ?
                      {{(CFG_DATA_W-2){1'b0}}, seed_mode_r} : '0;

  // ---------------------------------------------------------------
  // input handshake: held off while seeding or while an unread word
  // sits in the output register and the far side is stalling
  // ---------------------------------------------------------------
  assign in_stall = seed_stat.busy || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign next_acc = in_acc && (in_opcode == OP_NEXT);
  assign seed_acc = in_acc && (in_opcode == OP_SEED);

  // ---------------------------------------------------------------
  // seeder
  // ---------------------------------------------------------------
  mtp_seeder #(
    .STATE_WORDS (STATE_WORDS)
  ) u_seeder (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (seed_acc),
    .seed   (in_seed_value),
    .mode   (seed_mode_r),
    .status (seed_stat),
    .word   (seed_word)
  );

  // ---------------------------------------------------------------
  // twist of the word at the head of the chain; cell 1 and the offset
  // tap already hold new words once the ring has wrapped round
  // ---------------------------------------------------------------
  assign twist_y = (tap[0] & HIGH_BIT) | (tap[1] & LOW_BITS);
  assign twist_v = tap[TWIST_OFFSET] ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_MATRIX : '0);

  assign shift_en = next_acc || seed_stat.shift;
  assign feed     = seed_stat.busy ? seed_word : twist_v;

  // ---------------------------------------------------------------
  // ring of state cells, each loaded from its upper neighbour, the tail from the feed word
  // ---------------------------------------------------------------
  for (genvar i = 0; i < STATE_WORDS; i++) begin : g_cell
    if (i == STATE_WORDS - 1) begin : g_tail
      mtp_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .word_in  (feed),
        .word_out (tap[i])
      );
    end else begin : g_body
      mtp_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .word_in  (tap[i+1]),
        .word_out (tap[i])
      );
    end
  end

  // ---------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (next_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (next_acc) begin
      out_word_r <= temper(twist_v);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

endmodule

`default_nettype wire

FILE: sv/mtp_cell.sv
// one state word of the shift chain, loaded from its neighbour on every shift
`timescale 1ns / 1ps
`default_nettype none

module mtp_cell
  import mtp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              shift_en,
  input  wire logic [WORD_W-1:0] word_in,
  output logic      [WORD_W-1:0] word_out
);

  logic [WORD_W-1:0] word_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      word_r <= word_in;
    end
  end

  assign word_out = word_r;

endmodule

`default_nettype wire

FILE: sv/mtp_seeder.sv
// seed word generator, one state word per cycle into the tail of the chain
`timescale 1ns / 1ps
`default_nettype none

module mtp_seeder
  import mtp_pkg::*;
#(
  parameter int STATE_WORDS = STATE_WORDS_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] seed,
  input  wire logic [1:0]        mode,
  output seed_status_t           status,
  output logic      [WORD_W-1:0] word
);

  localparam int CNT_W = $clog2(STATE_WORDS);

  logic [WORD_W-1:0] gen_r;
  logic [WORD_W-1:0] gen_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [1:0]        mode_r;
  logic              busy_r;

  logic [WORD_W-1:0] mul_src;
  logic [WORD_W-1:0] mul_k;
  logic [WORD_W-1:0] addend;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] step1;
  logic              last;

  assign last = (cnt_r == CNT_W'(STATE_WORDS - 1));

  always_comb begin
    mul_src = gen_r;
    mul_k   = KNUTH_MUL;
    addend  = '0;
    unique case (mode_r)
      MODE_KNUTH: begin
      end
      MODE_CLASSIC: begin
        mul_k  = KNUTH_SQ;
        addend = CLASSIC_ADD;
      end
      default: begin
        // improved rule, also taken by the unused mode code
        mul_src = gen_r ^ (gen_r >> 30);
        mul_k   = INIT_MUL;
        addend  = {{(WORD_W-CNT_W){1'b0}}, cnt_r} + 32'd1;
      end
    endcase
  end

  assign prod    = mul_src * mul_k;
  assign gen_nxt = prod + addend;

  // classic rule: high half of s over high half of one lcg step later
  assign step1 = gen_r * KNUTH_MUL + 32'd1;
  assign word  = (mode_r == MODE_CLASSIC) ? ((gen_r & HALF_MASK) | (step1 >> 16)) : gen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (last) begin
        busy_r <= 1'b0;
      end
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      gen_r  <= seed;
      mode_r <= mode;
    end else if (busy_r) begin
      gen_r <= gen_nxt;
    end
  end

  assign status.busy  = busy_r;
  assign status.shift = busy_r;

endmodule

`default_nettype wire
